// ===== src/servo_pulse_angle_slew_unit_assert.svh =====
// Assertion macros used by the servo slew unit checker.
`ifndef SERVO_PULSE_ANGLE_SLEW_UNIT_ASSERT_SVH
`define SERVO_PULSE_ANGLE_SLEW_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SPASU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spasu check failed");

// Next-cycle implication, disabled while reset is low.
`define SPASU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spasu check failed");

`endif

// ===== src/spasu_pkg.sv =====
// Shared types and constants of the servo pulse angle slew unit.
`timescale 1ns / 1ps

package spasu_pkg;

    localparam int CENTER_W    = 24;
    localparam int GAIN_W      = 24;
    localparam int STEP_W      = 14;
    localparam int ANGLE_W     = 15;
    localparam int CFG_DATA_W  = 24;
    localparam int ROUND_SHIFT = 11;
    localparam int HALF_PI_Q13 = 12868;

    localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(1500);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(52707);
    localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(1638);

    typedef enum logic [1:0] {
        CFG_CONNECTED = 2'd0,
        CFG_CENTER    = 2'd1,
        CFG_GAIN      = 2'd2,
        CFG_SLEW      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                connected;
        logic [CENTER_W-1:0] center;
        logic [GAIN_W-1:0]   gain;
        logic [STEP_W-1:0]   slew_step;
    } t_cfg;

endpackage

// ===== src/spasu_cfg.sv =====
// Configuration register file of the servo slew unit.
`timescale 1ns / 1ps

module spasu_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic [1:0]                         i_index,
    input  logic [spasu_pkg::CFG_DATA_W-1:0]   i_data,
    output spasu_pkg::t_cfg                    o_cfg
);

    spasu_pkg::t_cfg r_cfg;

    // Take a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.connected <= 1'b0;
            r_cfg.center    <= spasu_pkg::CENTER_RST;
            r_cfg.gain      <= spasu_pkg::GAIN_RST;
            r_cfg.slew_step <= spasu_pkg::STEP_RST;
        end else if (i_wr) begin
            case (spasu_pkg::t_cfg_idx'(i_index))
                spasu_pkg::CFG_CONNECTED: r_cfg.connected <= i_data[0];
                spasu_pkg::CFG_CENTER:    r_cfg.center    <= i_data[spasu_pkg::CENTER_W-1:0];
                spasu_pkg::CFG_GAIN:      r_cfg.gain      <= i_data[spasu_pkg::GAIN_W-1:0];
                spasu_pkg::CFG_SLEW:      r_cfg.slew_step <= i_data[spasu_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/spasu_width.sv =====
// Pulse edge detection, saturating tick counter and width difference stage.
`timescale 1ns / 1ps

module spasu_width #(
    parameter int COUNT_BITS = 24,
    parameter int DIFF_W     = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  logic                             i_kind,
    input  logic                             i_level,
    input  spasu_pkg::t_cfg                  i_cfg,
    output logic                             o_valid,
    output logic                             o_kind,
    output logic                             o_fall,
    output logic                             o_neg,
    output logic [DIFF_W-1:0]                o_diff
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  r_prev_level;
    logic [COUNT_BITS-1:0] r_pulse_ticks;
    logic                  r_valid;
    logic                  r_kind;
    logic                  r_fall;
    logic                  r_neg;
    logic [DIFF_W-1:0]     r_diff;

    logic                  sample;
    logic                  rise;
    logic                  fall;
    logic [DIFF_W-1:0]     ticks_ext;
    logic [DIFF_W-1:0]     center_ext;
    logic                  neg;
    logic [COUNT_BITS-1:0] n_pulse_ticks;

    // Decode edges against the last level and measure against center
    always_comb begin
        sample     = i_valid && !i_kind && i_cfg.connected;
        rise       = i_level && !r_prev_level;
        fall       = !i_level && r_prev_level;
        ticks_ext  = DIFF_W'(r_pulse_ticks);
        center_ext = DIFF_W'(i_cfg.center);
        neg        = ticks_ext < center_ext;
        if (rise) begin
            n_pulse_ticks = COUNT_BITS'(1);
        end else if (r_pulse_ticks == COUNT_MAX) begin
            n_pulse_ticks = r_pulse_ticks;
        end else begin
            n_pulse_ticks = r_pulse_ticks + COUNT_BITS'(1);
        end
    end

    // Hold pin state and the tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b0;
            r_pulse_ticks <= '0;
        end else if (i_adv && sample) begin
            r_prev_level  <= i_level;
            r_pulse_ticks <= n_pulse_ticks;
        end
    end

    // Advance the item into the multiply stage; drop samples while disconnected
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid && (i_kind || i_cfg.connected);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_kind <= i_kind;
            r_fall <= sample && fall;
            r_neg  <= neg;
            r_diff <= neg ? (center_ext - ticks_ext) : (ticks_ext - center_ext);
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_fall  = r_fall;
    assign o_neg   = r_neg;
    assign o_diff  = r_diff;

endmodule

// ===== src/spasu_angle.sv =====
// Width-to-angle multiply stage, rounding and clamp into the target angle.
`timescale 1ns / 1ps

module spasu_angle #(
    parameter int DIFF_W = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_valid,
    input  logic                                   i_kind,
    input  logic                                   i_fall,
    input  logic                                   i_neg,
    input  logic [DIFF_W-1:0]                      i_diff,
    input  logic [spasu_pkg::GAIN_W-1:0]           i_gain,
    output logic                                   o_frame,
    output logic signed [spasu_pkg::ANGLE_W-1:0]   o_target
);

    localparam int PROD_W = DIFF_W + spasu_pkg::GAIN_W;
    localparam int MAG_W  = PROD_W - spasu_pkg::ROUND_SHIFT + 1;
    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(spasu_pkg::HALF_PI_Q13);

    logic                                 r_valid;
    logic                                 r_kind;
    logic                                 r_fall;
    logic                                 r_neg;
    logic [PROD_W-1:0]                    r_prod;
    logic signed [spasu_pkg::ANGLE_W-1:0] r_target;

    logic [MAG_W-1:0]                     mag;
    logic [spasu_pkg::ANGLE_W-1:0]        mag_clamped;
    logic signed [spasu_pkg::ANGLE_W-1:0] n_target;

    // Multiply the width difference by the gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_kind <= i_kind;
            r_fall <= i_fall;
            r_neg  <= i_neg;
            r_prod <= PROD_W'(i_diff) * PROD_W'(i_gain);
        end
    end

    // Round half away from zero, clamp to a quarter turn, apply the sign
    always_comb begin
        mag = MAG_W'(r_prod[PROD_W-1:spasu_pkg::ROUND_SHIFT])
            + MAG_W'(r_prod[spasu_pkg::ROUND_SHIFT-1]);
        mag_clamped = (mag > MAG_MAX) ? spasu_pkg::ANGLE_W'(spasu_pkg::HALF_PI_Q13)
                                      : mag[spasu_pkg::ANGLE_W-1:0];
        n_target = r_neg ? -$signed(mag_clamped) : $signed(mag_clamped);
    end

    // Update the target on a falling edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_adv && r_valid && !r_kind && r_fall) begin
            r_target <= n_target;
        end
    end

    assign o_frame  = r_valid && r_kind;
    assign o_target = r_target;

endmodule

// ===== src/spasu_slew.sv =====
// Slew limiter, change flag and result register.
`timescale 1ns / 1ps

module spasu_slew (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_frame,
    input  logic signed [spasu_pkg::ANGLE_W-1:0]   i_target,
    input  logic [spasu_pkg::STEP_W-1:0]           i_step,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [spasu_pkg::ANGLE_W-1:0]   o_angle,
    output logic                                   o_changed
);

    localparam int SUM_W = spasu_pkg::ANGLE_W + 2;

    logic signed [spasu_pkg::ANGLE_W-1:0] r_current;
    logic signed [spasu_pkg::ANGLE_W-1:0] r_reported;
    logic                                 r_out_valid;
    logic signed [spasu_pkg::ANGLE_W-1:0] r_out_angle;
    logic                                 r_out_changed;

    logic signed [SUM_W-1:0]              cur_ext;
    logic signed [SUM_W-1:0]              tgt_ext;
    logic signed [SUM_W-1:0]              step_ext;
    logic signed [SUM_W-1:0]              moved;
    logic signed [spasu_pkg::ANGLE_W-1:0] n_current;

    // Move toward the target by at most one step, never past it
    always_comb begin
        cur_ext  = SUM_W'(r_current);
        tgt_ext  = SUM_W'(i_target);
        step_ext = $signed(SUM_W'(i_step));
        moved    = cur_ext;
        if (cur_ext > tgt_ext) begin
            moved = cur_ext - step_ext;
            if (moved < tgt_ext) begin
                moved = tgt_ext;
            end
        end else if (cur_ext < tgt_ext) begin
            moved = cur_ext + step_ext;
            if (moved > tgt_ext) begin
                moved = tgt_ext;
            end
        end
        n_current = moved[spasu_pkg::ANGLE_W-1:0];
    end

    // Hold the angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current  <= '0;
            r_reported <= '0;
        end else if (i_adv && i_frame) begin
            r_current  <= n_current;
            r_reported <= n_current;
        end
    end

    // Load the result item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv && i_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_frame) begin
            r_out_angle   <= n_current;
            r_out_changed <= n_current != r_reported;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_out_angle;
    assign o_changed   = r_out_changed;

endmodule

// ===== src/servo_pulse_angle_slew_unit.sv =====
// Top level of the servo pulse angle slew unit.
//
//  channel   dir  handshake                       content
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[0] pin_level, tuser kind
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata[14:0] shaft_angle,
//                                                 tuser angle_changed
//
// One item per cycle while input ready is high. A frame tick's result passes through the input,
// difference, multiply and result registers in that order. Sample ticks give no result.
// Reset is synchronous and active low; config takes every write at once.
// Input ready drops only while a frame tick waits in the target stage and the
// result register holds an item not yet taken.
`timescale 1ns / 1ps

module servo_pulse_angle_slew_unit #(
    parameter int COUNT_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [spasu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [0] pin_level, [7:1] zero
    input  logic                               s_axis_tuser,  // [0] kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [14:0] shaft_angle, [15] zero
    output logic                               m_axis_tuser   // [0] angle_changed
);

    localparam int DIFF_W = (COUNT_BITS > spasu_pkg::CENTER_W) ? COUNT_BITS
                                                               : spasu_pkg::CENTER_W;

    spasu_pkg::t_cfg                      cfg;
    logic                                 adv;
    logic                                 r_s1_valid;
    logic                                 r_s1_kind;
    logic                                 r_s1_level;
    logic                                 s2_valid;
    logic                                 s2_kind;
    logic                                 s2_fall;
    logic                                 s2_neg;
    logic [DIFF_W-1:0]                    s2_diff;
    logic                                 s3_frame;
    logic signed [spasu_pkg::ANGLE_W-1:0] target;
    logic                                 out_valid;
    logic signed [spasu_pkg::ANGLE_W-1:0] out_angle;
    logic                                 out_changed;

    // Stall the pipe only when a frame result has nowhere to go
    assign adv           = !(s3_frame && out_valid && !m_axis_tready);
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind  <= s_axis_tuser;
            r_s1_level <= s_axis_tdata[0];
        end
    end

    spasu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    spasu_width #(
        .COUNT_BITS (COUNT_BITS),
        .DIFF_W     (DIFF_W)
    ) u_width (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s1_valid),
        .i_kind  (r_s1_kind),
        .i_level (r_s1_level),
        .i_cfg   (cfg),
        .o_valid (s2_valid),
        .o_kind  (s2_kind),
        .o_fall  (s2_fall),
        .o_neg   (s2_neg),
        .o_diff  (s2_diff)
    );

    spasu_angle #(
        .DIFF_W (DIFF_W)
    ) u_angle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (s2_valid),
        .i_kind   (s2_kind),
        .i_fall   (s2_fall),
        .i_neg    (s2_neg),
        .i_diff   (s2_diff),
        .i_gain   (cfg.gain),
        .o_frame  (s3_frame),
        .o_target (target)
    );

    spasu_slew u_slew (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_frame     (s3_frame),
        .i_target    (target),
        .i_step      (cfg.slew_step),
        .i_out_ready (m_axis_tready),
        .o_out_valid (out_valid),
        .o_angle     (out_angle),
        .o_changed   (out_changed)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {1'b0, out_angle};
    assign m_axis_tuser  = out_changed;

endmodule

// ===== src/spasu_checker.sv =====
// Port-level checker for the servo slew unit, bound to the top level.
`timescale 1ns / 1ps
`include "servo_pulse_angle_slew_unit_assert.svh"

module spasu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic        out_take;
    logic [14:0] r_last_angle;

    assign out_take = m_axis_tvalid && m_axis_tready;

    // Track the last delivered angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
        end else if (out_take) begin
            r_last_angle <= m_axis_tdata[14:0];
        end
    end

    // A stalled result holds
    `SPASU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Angle stays within a quarter turn, padding bit zero
    `SPASU_ASSERT_NOW(a_angle_range, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata[14:0]) <= 15'sd12868) && ($signed(m_axis_tdata[14:0]) >= -15'sd12868) && (m_axis_tdata[15] == 1'b0))

    // Change flag agrees with the previous delivered angle
    `SPASU_ASSERT_NOW(a_changed_flag, i_clk, i_rst_n, out_take, m_axis_tuser == (m_axis_tdata[14:0] != r_last_angle))

endmodule

bind servo_pulse_angle_slew_unit spasu_checker u_spasu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/servo_pulse_angle_slew_unit_tb.sv =====
// Self-checking testbench of the servo pulse angle slew unit.
`timescale 1ns / 1ps

module servo_pulse_angle_slew_unit_tb;

    // Counter width of the block under test
    localparam int              CNT_W          = 12;
    localparam longint unsigned COUNT_MAX      = (64'd1 << CNT_W) - 1;
    localparam logic            KIND_SAMPLE    = 1'b0;
    localparam logic            KIND_FRAME     = 1'b1;
    localparam int              DRAIN_CYCLES   = 8;
    localparam int              WATCHDOG_LIMIT = 3000;

    localparam logic [spasu_pkg::CFG_DATA_W-1:0] CFG_HALF_PI =
        spasu_pkg::CFG_DATA_W'(spasu_pkg::HALF_PI_Q13);
    localparam logic [spasu_pkg::CFG_DATA_W-1:0] CFG_STEP_RST =
        spasu_pkg::CFG_DATA_W'(spasu_pkg::STEP_RST);

    typedef struct {
        logic [spasu_pkg::ANGLE_W-1:0] angle;
        logic                          changed;
    } angle_rec_t;

    // Tracks the servo state and holds the angles still to come out
    class angle_predictor;
        logic                           connected;
        logic [spasu_pkg::CENTER_W-1:0] center;
        logic [spasu_pkg::GAIN_W-1:0]   gain;
        logic [spasu_pkg::STEP_W-1:0]   slew;
        logic                           prev_level;
        longint unsigned                pulse_ticks;
        int                             target;
        int                             current;
        int                             reported;
        angle_rec_t                     pending[$];
        int                             errors;

        function new();
            connected   = 1'b0;
            center      = spasu_pkg::CENTER_RST;
            gain        = spasu_pkg::GAIN_RST;
            slew        = spasu_pkg::STEP_RST;
            prev_level  = 1'b0;
            pulse_ticks = 0;
            target      = 0;
            current     = 0;
            reported    = 0;
            errors      = 0;
        endfunction

        task flag_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(input spasu_pkg::t_cfg_idx idx,
                                input logic [spasu_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spasu_pkg::CFG_CONNECTED: connected = data[0];
                spasu_pkg::CFG_CENTER:    center    = data[spasu_pkg::CENTER_W-1:0];
                spasu_pkg::CFG_GAIN:      gain      = data[spasu_pkg::GAIN_W-1:0];
                spasu_pkg::CFG_SLEW:      slew      = data[spasu_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // Scale the pulse width offset, round half away from zero, clamp to pi/2
        function int pulse_to_target(input longint unsigned ticks);
            logic            neg;
            longint unsigned ctr;
            longint unsigned diff;
            longint unsigned mag;
            ctr  = longint'(center);
            neg  = ticks < ctr;
            diff = neg ? ctr - ticks : ticks - ctr;
            mag  = (diff * longint'(gain) + 1024) >> spasu_pkg::ROUND_SHIFT;
            if (mag > spasu_pkg::HALF_PI_Q13) mag = spasu_pkg::HALF_PI_Q13;
            return neg ? -int'(mag) : int'(mag);
        endfunction

        function void apply_item(input logic kind, input logic level);
            angle_rec_t rec;
            if (kind == KIND_SAMPLE) begin
                if (!connected) return;
                if (level && !prev_level) pulse_ticks = 0;
                if (!level && prev_level) target = pulse_to_target(pulse_ticks);
                prev_level = level;
                if (pulse_ticks < COUNT_MAX) pulse_ticks++;
                return;
            end
            // Slew toward the target by at most one step
            if (current > target) begin
                current -= int'(slew);
                if (current < target) current = target;
            end else if (current < target) begin
                current += int'(slew);
                if (current > target) current = target;
            end
            rec.angle   = current[spasu_pkg::ANGLE_W-1:0];
            rec.changed = (current != reported);
            reported    = current;
            pending.push_back(rec);
        endfunction

        task compare_angle(input logic [spasu_pkg::ANGLE_W-1:0] angle, input logic changed);
            angle_rec_t want;
            if (pending.size() == 0) begin
                flag_mismatch($sformatf("angle %0d with none expected", $signed(angle)));
                return;
            end
            want = pending.pop_front();
            if (angle !== want.angle)
                flag_mismatch($sformatf("shaft_angle got %0d want %0d",
                                        $signed(angle), $signed(want.angle)));
            if (changed !== want.changed)
                flag_mismatch($sformatf("angle_changed got %b want %b", changed, want.changed));
        endtask
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [1:0]                       i_cfg_index;
    logic [spasu_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [0] pin_level, [7:1] zero
    logic                             s_axis_tuser;   // [0] kind
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [15:0]                      m_axis_tdata;   // [14:0] shaft_angle, [15] zero
    logic                             m_axis_tuser;   // [0] angle_changed

    angle_predictor sb = new();
    logic           no_gaps = 1'b0;
    int             idle_cycles = 0;
    int             items_sent = 0;

    servo_pulse_angle_slew_unit #(
        .COUNT_BITS(CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, none while gaps are switched off
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the result side at random
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall = pick_gap();
            end
        end
    end

    // Check results and count cycles without progress
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.compare_angle(m_axis_tdata[spasu_pkg::ANGLE_W-1:0], m_axis_tuser);
        if (i_rst_n && !((s_axis_tvalid && s_axis_tready) ||
                         (m_axis_tvalid && m_axis_tready) ||
                         (i_cfg_valid && o_cfg_ready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(input spasu_pkg::t_cfg_idx idx,
                             input logic [spasu_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Drop the write strobe after the last register write
    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [spasu_pkg::CFG_DATA_W-1:0] conn,
                             input logic [spasu_pkg::CFG_DATA_W-1:0] ctr,
                             input logic [spasu_pkg::CFG_DATA_W-1:0] gn,
                             input logic [spasu_pkg::CFG_DATA_W-1:0] stp);
        write_reg(spasu_pkg::CFG_CONNECTED, conn);
        write_reg(spasu_pkg::CFG_CENTER, ctr);
        write_reg(spasu_pkg::CFG_GAIN, gn);
        write_reg(spasu_pkg::CFG_SLEW, stp);
        end_writes();
    endtask

    task automatic send_item(input logic kind, input logic level);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, level};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.apply_item(kind, level);
        items_sent++;
    endtask

    // High for the given number of samples, then one low sample
    task automatic send_pulse(input int width);
        repeat (width) send_item(KIND_SAMPLE, 1'b1);
        send_item(KIND_SAMPLE, 1'b0);
    endtask

    // Drop valid and wait until the block has gone quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed pulses followed by frame ticks, some noise
    task automatic run_random(input int n_items, input int max_width);
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                repeat ($urandom_range(1, 3)) send_item(KIND_SAMPLE, 1'b0);
                send_pulse($urandom_range(1, max_width));
                repeat ($urandom_range(1, 4))
                    send_item(KIND_FRAME, 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                repeat ($urandom_range(1, 3))
                    send_item(KIND_FRAME, 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = spasu_pkg::CFG_CONNECTED;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = KIND_SAMPLE;
        s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Disconnected after reset: samples ignored, frames still report
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_SAMPLE, 1'b1);
        send_item(KIND_FRAME, 1'b1);
        settle();

        // Halfway rounding, short pulse below center, repeated frame with no change
        configure(1, 3, 1024, 1000);
        send_item(KIND_SAMPLE, 1'b0);
        send_pulse(4);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b0);
        send_pulse(1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b0);
        settle();

        // Positive clamp with a step of a quarter turn
        configure(1, 0, 24'hFFFFFF, CFG_HALF_PI);
        send_pulse(2);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b0);
        settle();

        // Negative clamp with zero step: the angle holds
        configure(1, 24'hFFFFFF, 3, 0);
        send_pulse(1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b0);
        settle();

        // Reset-value gain and step around a short center
        write_reg(spasu_pkg::CFG_CENTER, 24'd20);
        write_reg(spasu_pkg::CFG_GAIN, spasu_pkg::GAIN_RST);
        write_reg(spasu_pkg::CFG_SLEW, CFG_STEP_RST);
        end_writes();
        send_pulse(26);
        repeat (3) send_item(KIND_FRAME, 1'b0);
        send_pulse(14);
        repeat (3) send_item(KIND_FRAME, 1'b0);
        settle();

        // Random phases across register settings
        configure(1, 16, 600000, 1638);
        run_random(120, 40);

        no_gaps = 1'b1;
        configure(1, 0, 24'hFFFFFF, CFG_HALF_PI);
        run_random(80, 8);
        no_gaps = 1'b0;

        configure(1, 24'hFFFFFF, 3, 300);
        run_random(60, 20);

        configure(1, 10, 0, 1638);
        run_random(40, 20);

        configure(1, 20, 1024, 0);
        run_random(60, 40);

        configure(0, 20, 400000, 2000);
        run_random(60, 40);

        // Oversized values are cut to the register width
        configure(24'hFFFFFF, 12, 24'h0A0000, 24'hFFFFFF);
        run_random(80, 30);

        no_gaps = 1'($urandom_range(0, 1));
        configure(1, 30, 200000, 1638);
        run_random(80, 60);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
